[rtl/core/qps_pkg.sv]
// qps_pkg: shared types, codes and constants for the quadrature position and speed block
// no dependencies; imported by quadrature_position_and_speed, qps_checker and tb
package qps_pkg;

    // default and field widths
    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int INTERVAL_W = 10;
    localparam int CPR_W      = 16;
    localparam int POS_OUT_W  = 32;
    localparam int DELTA_W    = 21;
    localparam int SPEED_W    = 21;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // speed datapath widths
    localparam int DEN_W  = 26;   // interval * counts per rev
    localparam int MAG_W  = 41;   // magnitudes above 2**40 saturate directly
    localparam int SCALE_W = 20;
    localparam int PROD_W = MAG_W + SCALE_W;
    localparam int ALU_W  = PROD_W + 1;
    localparam int Q_W    = 20;
    localparam int STEP_W = 5;

    // register reset values
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd100;
    localparam logic [CPR_W-1:0]      CPR_RESET      = 16'd2240;

    // conversion constant: 60000 ms per minute times 10 tenths per rpm, folded to 600000
    localparam logic [SCALE_W-1:0] SPEED_SCALE = 20'd600000;
    localparam logic [Q_W-1:0]     SPEED_MAX   = 20'd999999;
    localparam int                 DELTA_MAX   = 1048575;
    localparam int                 DELTA_MIN   = -1048576;

    // request codes
    typedef enum logic [1:0] {
        REQ_PIN   = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    // register index within the config space
    typedef enum logic {
        REG_INTERVAL = 1'b0,
        REG_CPR      = 1'b1
    } reg_index_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_RESULT
    } state_t;

endpackage

[rtl/core/quadrature_position_and_speed.sv]
// quadrature_position_and_speed: quadrature decoder with periodic speed measurement
// depends on qps_pkg (types, codes, widths); single module, no memories
//
// Each transaction takes one of three requests: an encoder pin sample, a one millisecond
// tick or a position clear (the unused fourth code changes nothing), and returns exactly
// one result (position, held delta, held speed in tenths of rpm and a measured flag). Pin
// samples, clears and ticks that do not complete an interval go straight to the result
// state. A tick that completes an interval runs a setup step, 20 shift-add steps forming
// |delta|*600000, one range check, 20 restoring divide steps by interval times counts per
// revolution, and the result step; it skips to the result when |delta| exceeds 2**40, and
// past the divide when the range check saturates. The multiply, check and divide steps run
// through one shared 62-bit adder under a small sequencer, and in_ready is high only while
// it is idle; a waiting output register holds the result state until out_ready takes it.
module quadrature_position_and_speed
    import qps_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic                        pin_a,
    input  logic                        pin_b,
    // output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [POS_OUT_W-1:0] position,
    output logic signed [DELTA_W-1:0]   delta,
    output logic signed [SPEED_W-1:0]   rpm_tenths,
    output logic                        measured
);

    localparam int MW = (POSITION_BITS > MAG_W) ? POSITION_BITS : MAG_W;
    localparam int EW = (POSITION_BITS > DELTA_W) ? POSITION_BITS : DELTA_W;
    localparam logic [MW-1:0] MAG_LIMIT = MW'(64'd1 << (MAG_W - 1));
    localparam logic signed [EW-1:0] DELTA_HI = EW'(DELTA_MAX);
    localparam logic signed [EW-1:0] DELTA_LO = EW'(DELTA_MIN);

    // config registers
    logic [INTERVAL_W-1:0] cfg_interval_reg;
    logic [CPR_W-1:0]      cfg_cpr_reg;

    // control state
    state_t                state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  measure_reg, measure_next;
    logic                  sat_reg, sat_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  last_a_reg, last_a_next;
    logic                  last_b_reg, last_b_next;
    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic [POSITION_BITS-1:0] cal_reg, cal_next;
    logic [INTERVAL_W-1:0] ms_reg, ms_next;
    logic signed [DELTA_W-1:0] held_delta_reg, held_delta_next;
    logic signed [SPEED_W-1:0] held_speed_reg, held_speed_next;

    // arithmetic working registers
    logic                  sign_reg, sign_next;
    logic [MAG_W-1:0]      mag_reg, mag_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [PROD_W-1:0]     acc_reg, acc_next;
    logic [DEN_W-1:0]      rem_reg, rem_next;

    // output register
    logic signed [POS_OUT_W-1:0] position_reg, position_next;
    logic signed [DELTA_W-1:0]   delta_reg, delta_next;
    logic signed [SPEED_W-1:0]   speed_reg, speed_next;
    logic                        measured_reg, measured_next;

    // shared adder
    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_cin;

    // helper values
    logic [INTERVAL_W-1:0]    iv_eff;
    logic [CPR_W-1:0]         cpr_eff;
    logic [INTERVAL_W-1:0]    ms_inc;
    logic [POSITION_BITS-1:0] delta_raw, mag_u;
    logic [MW-1:0]            mag_ext;
    logic                     mag_big;
    logic signed [EW-1:0]     delta_ext;
    logic signed [DELTA_W-1:0] delta_sat;
    logic [DEN_W:0]           trial;
    logic                     qbit;
    logic [Q_W-1:0]           q_clip;
    logic signed [SPEED_W-1:0] speed_val;
    logic                     cfg_write;
    reg_index_t               cfg_index;

    // config port
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_interval_reg <= INTERVAL_RESET;
            cfg_cpr_reg      <= CPR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INTERVAL: cfg_interval_reg <= pwdata[INTERVAL_W-1:0];
                REG_CPR:      cfg_cpr_reg      <= pwdata[CPR_W-1:0];
                default:      ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_index)
            REG_INTERVAL: prdata = DATA_W'(cfg_interval_reg);
            REG_CPR:      prdata = DATA_W'(cfg_cpr_reg);
            default:      prdata = '0;
        endcase
    end

    // zero register values act as one
    assign iv_eff  = (cfg_interval_reg == '0) ? INTERVAL_W'(1) : cfg_interval_reg;
    assign cpr_eff = (cfg_cpr_reg == '0) ? CPR_W'(1) : cfg_cpr_reg;
    assign ms_inc  = ms_reg + INTERVAL_W'(1);

    // delta since last measurement, magnitude and saturated value
    assign delta_raw = count_reg - cal_reg;
    assign mag_u     = delta_raw[POSITION_BITS-1] ? (~delta_raw + POSITION_BITS'(1)) : delta_raw;
    assign mag_ext   = MW'(mag_u);
    assign mag_big   = mag_ext > MAG_LIMIT;
    assign delta_ext = EW'($signed(delta_raw));

    always_comb
    begin
        if (delta_ext > DELTA_HI)
            delta_sat = DELTA_HI[DELTA_W-1:0];
        else if (delta_ext < DELTA_LO)
            delta_sat = DELTA_LO[DELTA_W-1:0];
        else
            delta_sat = delta_ext[DELTA_W-1:0];
    end

    // shared adder
    assign alu_sum = alu_a + alu_b + ALU_W'(alu_cin);

    // restoring divide step operands
    assign trial = {rem_reg, acc_reg[Q_W-1]};
    assign qbit  = !alu_sum[ALU_W-1];

    // final speed from quotient
    always_comb
    begin
        if (sat_reg || (acc_reg[Q_W-1:0] > SPEED_MAX))
            q_clip = SPEED_MAX;
        else
            q_clip = acc_reg[Q_W-1:0];
        speed_val = sign_reg ? -$signed(SPEED_W'(q_clip)) : $signed(SPEED_W'(q_clip));
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            measure_reg    <= 1'b0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_a_reg     <= 1'b0;
            last_b_reg     <= 1'b0;
            count_reg      <= '0;
            cal_reg        <= '0;
            ms_reg         <= '0;
            held_delta_reg <= '0;
            held_speed_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            measure_reg    <= measure_next;
            sat_reg        <= sat_next;
            out_valid_reg  <= out_valid_next;
            last_a_reg     <= last_a_next;
            last_b_reg     <= last_b_next;
            count_reg      <= count_next;
            cal_reg        <= cal_next;
            ms_reg         <= ms_next;
            held_delta_reg <= held_delta_next;
            held_speed_reg <= held_speed_next;
        end
    end

    // datapath and output payload registers
    always_ff @(posedge clk)
    begin
        sign_reg     <= sign_next;
        mag_reg      <= mag_next;
        den_reg      <= den_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        position_reg <= position_next;
        delta_reg    <= delta_next;
        speed_reg    <= speed_next;
        measured_reg <= measured_next;
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        measure_next    = measure_reg;
        sat_next        = sat_reg;
        out_valid_next  = out_valid_reg;
        last_a_next     = last_a_reg;
        last_b_next     = last_b_reg;
        count_next      = count_reg;
        cal_next        = cal_reg;
        ms_next         = ms_reg;
        held_delta_next = held_delta_reg;
        held_speed_next = held_speed_reg;
        sign_next       = sign_reg;
        mag_next        = mag_reg;
        den_next        = den_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        position_next   = position_reg;
        delta_next      = delta_reg;
        speed_next      = speed_reg;
        measured_next   = measured_reg;
        alu_a           = '0;
        alu_b           = '0;
        alu_cin         = 1'b0;
        in_ready        = (state_reg == ST_IDLE);

        // output transaction taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    measure_next = 1'b0;
                    sat_next     = 1'b0;
                    state_next   = ST_RESULT;
                    case (req_t'(req_type))
                        REQ_PIN:
                        begin
                            if (pin_a != last_a_reg)
                            begin
                                count_next  = (pin_a == pin_b) ? count_reg + POSITION_BITS'(1)
                                                               : count_reg - POSITION_BITS'(1);
                                last_a_next = pin_a;
                            end
                            else if (pin_b != last_b_reg)
                            begin
                                count_next  = (pin_a != pin_b) ? count_reg + POSITION_BITS'(1)
                                                               : count_reg - POSITION_BITS'(1);
                                last_b_next = pin_b;
                            end
                        end
                        REQ_TICK:
                        begin
                            if ((ms_inc >= iv_eff) || (ms_inc == '0))
                            begin
                                ms_next         = '0;
                                measure_next    = 1'b1;
                                cal_next        = count_reg;
                                sign_next       = delta_raw[POSITION_BITS-1];
                                mag_next        = mag_ext[MAG_W-1:0];
                                sat_next        = mag_big;
                                den_next        = DEN_W'(iv_eff) * DEN_W'(cpr_eff);
                                held_delta_next = delta_sat;
                                acc_next        = '0;
                                step_next       = STEP_W'(SCALE_W - 1);
                                state_next      = mag_big ? ST_RESULT : ST_MUL;
                            end
                            else
                            begin
                                ms_next = ms_inc;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            cal_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // shift-add multiply by the speed scale, msb first
            ST_MUL:
            begin
                alu_a    = ALU_W'({acc_reg[PROD_W-2:0], 1'b0});
                alu_b    = SPEED_SCALE[step_reg] ? ALU_W'(mag_reg) : '0;
                acc_next = alu_sum[PROD_W-1:0];
                if (step_reg == '0)
                    state_next = ST_CHK;
                else
                    step_next = step_reg - STEP_W'(1);
            end

            // quotient at or above 2**20 saturates
            ST_CHK:
            begin
                alu_a   = ALU_W'(acc_reg[PROD_W-1:Q_W]);
                alu_b   = ~ALU_W'(den_reg);
                alu_cin = 1'b1;
                if (!alu_sum[ALU_W-1])
                begin
                    sat_next   = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    rem_next   = acc_reg[Q_W+DEN_W-1:Q_W];
                    step_next  = STEP_W'(Q_W - 1);
                    state_next = ST_DIV;
                end
            end

            // restoring divide, quotient bits shift into the low product bits
            ST_DIV:
            begin
                alu_a    = ALU_W'(trial);
                alu_b    = ~ALU_W'(den_reg);
                alu_cin  = 1'b1;
                rem_next = qbit ? alu_sum[DEN_W-1:0] : trial[DEN_W-1:0];
                acc_next = {acc_reg[PROD_W-1:Q_W], acc_reg[Q_W-2:0], qbit};
                if (step_reg == '0)
                    state_next = ST_RESULT;
                else
                    step_next = step_reg - STEP_W'(1);
            end

            // load the output register once it is free
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (measure_reg)
                        held_speed_next = speed_val;
                    position_next  = POS_OUT_W'($signed(count_reg));
                    delta_next     = held_delta_reg;
                    speed_next     = measure_reg ? speed_val : held_speed_reg;
                    measured_next  = measure_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign position   = position_reg;
    assign delta      = delta_reg;
    assign rpm_tenths = speed_reg;
    assign measured   = measured_reg;

`ifndef NO_ASSERTIONS
    // an accepted transaction always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after accepting a transaction");

    // divide remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divide remainder not below divisor");

    // a result appears only from the result state
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RESULT))
        else $error("output valid rose outside the result state");

    // reported speed stays within range and agrees in sign with delta
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((speed_reg <= 21'sd999999) && (speed_reg >= -21'sd999999)))
        else $error("speed out of range");

    a_speed_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (speed_reg != '0)) |-> (speed_reg[SPEED_W-1] == delta_reg[DELTA_W-1]))
        else $error("speed sign differs from delta sign");
`endif

endmodule

[verif/qps_checker.sv]
`timescale 1ns / 1ps
// qps_checker: watches the config port and both channels of the quadrature position and
// speed block, predicts each result and compares it; depends on qps_pkg only
module qps_checker
    import qps_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    // input channel
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic                        pin_a,
    input  logic                        pin_b,
    // output channel
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [POS_OUT_W-1:0] position,
    input  logic signed [DELTA_W-1:0]   delta,
    input  logic signed [SPEED_W-1:0]   rpm_tenths,
    input  logic                        measured,
    output int                          fail_count
);

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [POS_OUT_W-1:0] position;
        logic signed [DELTA_W-1:0]   delta;
        logic signed [SPEED_W-1:0]   speed;
        logic                        measured;
    } reading_t;

    // shadow of the registers
    logic [INTERVAL_W-1:0] interval_ms;
    logic [CPR_W-1:0]      rev_counts;

    // shadow of the decoder and speed state
    logic                              level_a;
    logic                              level_b;
    logic [POSITION_BITS_DEFAULT-1:0]  count;
    logic [POSITION_BITS_DEFAULT-1:0]  count_ref;
    logic [INTERVAL_W-1:0]             ms_count;
    logic signed [DELTA_W-1:0]         held_delta;
    logic signed [SPEED_W-1:0]         held_speed;

    reading_t pending_readings[$];
    reading_t want;
    int       error_count;

    // delta since the last measurement and speed in tenths of rpm
    function automatic void take_measurement();
        logic signed [POSITION_BITS_DEFAULT-1:0] diff;
        longint travel;
        longint mag;
        longint span;
        longint rate;
        diff = count - count_ref;
        travel = longint'(diff);
        mag = (travel < 0) ? -travel : travel;
        span = (interval_ms == '0) ? 64'sd1 : longint'(interval_ms);
        span = span * ((rev_counts == '0) ? 64'sd1 : longint'(rev_counts));
        rate = mag * longint'(SPEED_SCALE) / span;
        if (rate > longint'(SPEED_MAX))
            rate = longint'(SPEED_MAX);
        held_speed = SPEED_W'((travel < 0) ? -rate : rate);
        if (travel > longint'(DELTA_MAX))
            held_delta = DELTA_W'(DELTA_MAX);
        else if (travel < longint'(DELTA_MIN))
            held_delta = DELTA_W'(DELTA_MIN);
        else
            held_delta = DELTA_W'(travel);
        count_ref = count;
    endfunction

    // apply one transaction to the shadow state and return the result it causes
    function automatic reading_t predict_reading(logic [1:0] req, logic a, logic b);
        reading_t r;
        logic [INTERVAL_W-1:0] period;
        r.measured = 1'b0;
        period = (interval_ms == '0) ? INTERVAL_W'(1) : interval_ms;
        case (req)
            REQ_PIN:
            begin
                if (a != level_a)
                begin
                    count = (a == b) ? count + 1'b1 : count - 1'b1;
                    level_a = a;
                end
                else if (b != level_b)
                begin
                    count = (a != b) ? count + 1'b1 : count - 1'b1;
                    level_b = b;
                end
            end
            REQ_TICK:
            begin
                ms_count = ms_count + 1'b1;
                if (ms_count >= period || ms_count == '0)
                begin
                    ms_count = '0;
                    take_measurement();
                    r.measured = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                count = '0;
                count_ref = '0;
            end
            default: ;
        endcase
        r.position = POS_OUT_W'(signed'(count));
        r.delta = held_delta;
        r.speed = held_speed;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint exp_val, input longint got_val);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, exp_val, got_val);
    endtask

    // compare results, predict new transactions, follow register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_ms = INTERVAL_RESET;
            rev_counts = CPR_RESET;
            level_a = 1'b0;
            level_b = 1'b0;
            count = '0;
            count_ref = '0;
            ms_count = '0;
            held_delta = '0;
            held_speed = '0;
            pending_readings.delete();
            error_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("[%0t] result with no pending transaction, position %0d",
                                 $time, position);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (want.position !== position)
                        note_mismatch("position", want.position, position);
                    if (want.delta !== delta)
                        note_mismatch("delta", want.delta, delta);
                    if (want.speed !== rpm_tenths)
                        note_mismatch("rpm_tenths", want.speed, rpm_tenths);
                    if (want.measured !== measured)
                        note_mismatch("measured", want.measured, measured);
                end
            end
            if (in_valid && in_ready)
                pending_readings.push_back(predict_reading(req_type, pin_a, pin_b));
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[ADDR_W-1:2] == (ADDR_W-2)'(REG_INTERVAL))
                    interval_ms = pwdata[INTERVAL_W-1:0];
                else if (paddr[ADDR_W-1:2] == (ADDR_W-2)'(REG_CPR))
                    rev_counts = pwdata[CPR_W-1:0];
            end
        end
        fail_count <= error_count + pending_readings.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// tb: stimulus and verdict for quadrature_position_and_speed
// depends on qps_pkg, the block itself and qps_checker, which does all prediction
module tb;
    import qps_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_GAP     = 12;
    localparam int HOLD_AT     = 130;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [DATA_W-1:0]           pwdata;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  req_type;
    logic                        pin_a;
    logic                        pin_b;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [POS_OUT_W-1:0] position;
    logic signed [DELTA_W-1:0]   delta;
    logic signed [SPEED_W-1:0]   rpm_tenths;
    logic                        measured;

    int fail_count;
    int tx_count = 0;
    int rx_count = 0;
    int send_calm = 0;
    int take_calm = 0;
    int shaft_step = 0;

    quadrature_position_and_speed dut (
        .clk, .rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .in_valid, .in_ready, .req_type, .pin_a, .pin_b,
        .out_valid, .out_ready, .position, .delta, .rpm_tenths, .measured
    );

    qps_checker u_reading_check (
        .clk, .rst_n,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .in_valid, .in_ready, .req_type, .pin_a, .pin_b,
        .out_valid, .out_ready, .position, .delta, .rpm_tenths, .measured,
        .fail_count
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // idle cycles before a transaction, with occasional runs of back-to-back ones
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // offer one transaction and wait until it is taken
    task automatic send(input logic [1:0] req, input logic a, input logic b);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type <= req;
        pin_a <= a;
        pin_b <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        tx_count++;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // drain the block, then write both registers with junk in the unused bits
    task automatic configure(input logic [INTERVAL_W-1:0] iv, input logic [CPR_W-1:0] cpr);
        logic [DATA_W-1:0] junk;
        in_valid <= 1'b0;
        while (rx_count != tx_count)
            @(posedge clk);
        repeat (4) @(posedge clk);
        junk = $urandom;
        write_reg(REG_INTERVAL, {junk[DATA_W-1:INTERVAL_W], iv});
        junk = $urandom;
        write_reg(REG_CPR, {junk[DATA_W-1:CPR_W], cpr});
    endtask

    // shaft motion as gray-coded pin samples, mixed with ticks, clears and noise
    task automatic run_motion(input int n_items);
        int pick;
        int heading;
        logic [1:0] quad;
        heading = ($urandom_range(0, 1) == 1) ? 1 : -1;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if ($urandom_range(0, 9) == 0)
                    heading = -heading;
                if ($urandom_range(0, 7) != 0)
                    shaft_step += heading;
                quad = 2'(shaft_step);
                send(REQ_PIN, quad[0] ^ quad[1], quad[1]);
            end
            else if (pick < 85)
                send(REQ_TICK, 1'($urandom), 1'($urandom));
            else if (pick < 88)
                send(REQ_CLEAR, 1'($urandom), 1'($urandom));
            else if (pick < 95)
                send(REQ_PIN, 1'($urandom), 1'($urandom));
            else
                send(REQ_UNUSED, 1'($urandom), 1'($urandom));
        end
    endtask

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && rx_count >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = draw_gap(take_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            rx_count++;
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= REQ_PIN;
        pin_a <= 1'b0;
        pin_b <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a tick that does not measure, one full quadrature cycle each way
        send(REQ_TICK, 1'b0, 1'b0);
        send(REQ_PIN, 1'b1, 1'b0);
        send(REQ_PIN, 1'b1, 1'b1);
        send(REQ_PIN, 1'b0, 1'b1);
        send(REQ_PIN, 1'b0, 1'b0);
        send(REQ_PIN, 1'b0, 1'b1);
        send(REQ_PIN, 1'b1, 1'b1);
        send(REQ_PIN, 1'b1, 1'b0);
        send(REQ_PIN, 1'b0, 1'b0);
        // both channels change at once: a is taken first, b on the repeat
        send(REQ_PIN, 1'b1, 1'b1);
        send(REQ_PIN, 1'b1, 1'b1);
        // unused request code, then a clear
        send(REQ_UNUSED, 1'b1, 1'b0);
        send(REQ_CLEAR, 1'b0, 1'b1);

        // every tick measures, speed saturates from two counts on
        configure(10'd1, 16'd1);
        send(REQ_PIN, 1'b0, 1'b1);
        send(REQ_TICK, 1'b1, 1'b1);
        send(REQ_PIN, 1'b0, 1'b0);
        send(REQ_PIN, 1'b1, 1'b0);
        send(REQ_TICK, 1'b0, 1'b0);
        send(REQ_TICK, 1'b0, 1'b0);

        // zero in either register acts as one
        configure(10'd0, 16'd0);
        send(REQ_PIN, 1'b1, 1'b1);
        send(REQ_TICK, 1'b0, 1'b0);

        // long interval, then lowered below the time already elapsed
        configure(10'd1000, 16'hFFFF);
        send(REQ_TICK, 1'b0, 1'b0);
        send(REQ_TICK, 1'b0, 1'b0);
        send(REQ_TICK, 1'b0, 1'b0);
        configure(10'd2, 16'hFFFF);
        send(REQ_TICK, 1'b0, 1'b0);

        // random motion under several settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: configure(10'd1, CPR_W'($urandom_range(1, 8)));
                1: configure(INTERVAL_W'($urandom_range(2, 6)),
                             CPR_W'($urandom_range(1, 65535)));
                2: configure(10'd0, 16'hFFFF);
                3: configure(10'h3FF, 16'd0);
                4: configure(10'd3, CPR_RESET);
                default: configure(INTERVAL_W'($urandom_range(1, 4)), CPR_W'($urandom));
            endcase
            run_motion((ph == 3) ? 30 : 80);
        end

        // drain and decide
        in_valid <= 1'b0;
        while (rx_count != tx_count)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
